// ===== sv/qrm_pkg.sv =====
`default_nettype none
package qrm_pkg;

   localparam int NumEnt    = 9;
   localparam int NumProd   = 10;
   localparam int DivSteps  = 32;
   localparam int NumStages = DivSteps + 4;
   localparam int NormW     = 65;
   localparam int RemW      = 66;
   localparam int NumW      = 67;
   localparam int QuoW      = 32;

   localparam logic [QuoW-1:0] OneQ30 = 32'h4000_0000;

   // product order
   localparam int PWW = 0;
   localparam int PXX = 1;
   localparam int PYY = 2;
   localparam int PZZ = 3;
   localparam int PXY = 4;
   localparam int PWZ = 5;
   localparam int PXZ = 6;
   localparam int PWY = 7;
   localparam int PYZ = 8;
   localparam int PWX = 9;

   typedef logic [RemW-1:0] rem_type;

   typedef struct packed {
      rem_type [NumEnt-1:0]           rem;
      logic [NumEnt-1:0][QuoW-1:0]    quo;
      logic [NumEnt-1:0]              neg;
      logic [NormW-1:0]               norm;
      logic                           zero;
   } div_type;

   typedef struct packed {
      rem_type rem;
      logic    qbit;
   } step_type;

   // one restoring division step; the remainder always stays below the norm
   function automatic step_type div_step(rem_type rem, logic [NormW-1:0] norm, logic shift);
      rem_type  r;
      rem_type  d;
      step_type s;
      r = shift ? {rem[RemW-2:0], 1'b0} : rem;
      d = {1'b0, norm};
      s.qbit = (r >= d);
      s.rem  = s.qbit ? (r - d) : r;
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== sv/qrm_ifs.sv =====
`default_nettype none
interface qrm_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] comp_w;
   logic signed [31:0] comp_x;
   logic signed [31:0] comp_y;
   logic signed [31:0] comp_z;

   modport source(output valid, comp_w, comp_x, comp_y, comp_z, input ready);
   modport sink(input valid, comp_w, comp_x, comp_y, comp_z, output ready);
endinterface

interface qrm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] m00;
   logic signed [31:0] m01;
   logic signed [31:0] m02;
   logic signed [31:0] m10;
   logic signed [31:0] m11;
   logic signed [31:0] m12;
   logic signed [31:0] m20;
   logic signed [31:0] m21;
   logic signed [31:0] m22;
   logic               zero_norm;

   modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                  input ready);
   modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, zero_norm,
                output ready);
endinterface
`default_nettype wire

// ===== sv/quaternion_to_rotation_matrix.sv =====
`default_nettype none
// channel   role    payload
// req_ch    sink    comp_w, comp_x, comp_y, comp_z   (Q3.28)
// rsp_ch    source  m00..m22 (Q1.30), zero_norm
//
// 36 stages: products, numerators and norm, magnitude, 32 divide steps
// (one quotient bit per stage), round/saturate into the output register.
// One transaction per cycle sustained while rsp_ch.ready stays high.
// Each stage loads when it is empty or the one after it moves, so bubbles
// close up under a stall. Reset (synchronous) clears the valid bits only.
module quaternion_to_rotation_matrix (
   input  wire logic  clock,
   input  wire logic  reset,
   qrm_req_if.sink    req_ch,
   qrm_rsp_if.source  rsp_ch
);

   localparam int NS = qrm_pkg::NumStages;
   localparam int NE = qrm_pkg::NumEnt;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_ch.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in = (en & {vld_ff[NS-2:0], req_ch.valid}) | (~en & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ch.ready = en[0];

   // products
   logic signed [63:0] prod_ff [qrm_pkg::NumProd];
   logic signed [63:0] prod_in [qrm_pkg::NumProd];

   always_comb begin
      prod_in[qrm_pkg::PWW] = 64'(req_ch.comp_w) * 64'(req_ch.comp_w);
      prod_in[qrm_pkg::PXX] = 64'(req_ch.comp_x) * 64'(req_ch.comp_x);
      prod_in[qrm_pkg::PYY] = 64'(req_ch.comp_y) * 64'(req_ch.comp_y);
      prod_in[qrm_pkg::PZZ] = 64'(req_ch.comp_z) * 64'(req_ch.comp_z);
      prod_in[qrm_pkg::PXY] = 64'(req_ch.comp_x) * 64'(req_ch.comp_y);
      prod_in[qrm_pkg::PWZ] = 64'(req_ch.comp_w) * 64'(req_ch.comp_z);
      prod_in[qrm_pkg::PXZ] = 64'(req_ch.comp_x) * 64'(req_ch.comp_z);
      prod_in[qrm_pkg::PWY] = 64'(req_ch.comp_w) * 64'(req_ch.comp_y);
      prod_in[qrm_pkg::PYZ] = 64'(req_ch.comp_y) * 64'(req_ch.comp_z);
      prod_in[qrm_pkg::PWX] = 64'(req_ch.comp_w) * 64'(req_ch.comp_x);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         prod_ff <= prod_in;
      end
   end

   // numerators and squared norm
   logic signed [qrm_pkg::NumW-1:0] num_ff [NE];
   logic signed [qrm_pkg::NumW-1:0] num_in [NE];
   logic [qrm_pkg::NormW-1:0]       norm_ff;
   logic [qrm_pkg::NormW-1:0]       norm_in;
   logic signed [qrm_pkg::NumW-1:0] pe [qrm_pkg::NumProd];

   always_comb begin
      for (int i = 0; i < qrm_pkg::NumProd; i++) begin
         pe[i] = qrm_pkg::NumW'(prod_ff[i]);
      end
      norm_in = qrm_pkg::NormW'(pe[qrm_pkg::PWW] + pe[qrm_pkg::PXX]
                                + pe[qrm_pkg::PYY] + pe[qrm_pkg::PZZ]);
      num_in[0] = pe[qrm_pkg::PWW] + pe[qrm_pkg::PXX] - pe[qrm_pkg::PYY] - pe[qrm_pkg::PZZ];
      num_in[1] = (pe[qrm_pkg::PXY] - pe[qrm_pkg::PWZ]) <<< 1;
      num_in[2] = (pe[qrm_pkg::PXZ] + pe[qrm_pkg::PWY]) <<< 1;
      num_in[3] = (pe[qrm_pkg::PXY] + pe[qrm_pkg::PWZ]) <<< 1;
      num_in[4] = pe[qrm_pkg::PWW] - pe[qrm_pkg::PXX] + pe[qrm_pkg::PYY] - pe[qrm_pkg::PZZ];
      num_in[5] = (pe[qrm_pkg::PYZ] - pe[qrm_pkg::PWX]) <<< 1;
      num_in[6] = (pe[qrm_pkg::PXZ] - pe[qrm_pkg::PWY]) <<< 1;
      num_in[7] = (pe[qrm_pkg::PYZ] + pe[qrm_pkg::PWX]) <<< 1;
      num_in[8] = pe[qrm_pkg::PWW] - pe[qrm_pkg::PXX] - pe[qrm_pkg::PYY] + pe[qrm_pkg::PZZ];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         num_ff  <= num_in;
         norm_ff <= norm_in;
      end
   end

   // sign/magnitude split
   qrm_pkg::div_type abs_ff;
   qrm_pkg::div_type abs_in;
   logic [qrm_pkg::NumW-1:0] neg_num;

   always_comb begin
      neg_num = '0;
      abs_in  = '0;
      for (int i = 0; i < NE; i++) begin
         neg_num        = -num_ff[i];
         abs_in.neg[i]  = num_ff[i][qrm_pkg::NumW-1];
         abs_in.rem[i]  = num_ff[i][qrm_pkg::NumW-1] ? neg_num[qrm_pkg::RemW-1:0]
                                                     : num_ff[i][qrm_pkg::RemW-1:0];
      end
      abs_in.norm = norm_ff;
      abs_in.zero = (norm_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         abs_ff <= abs_in;
      end
   end

   // divide: one quotient bit per stage
   qrm_pkg::div_type chain [qrm_pkg::DivSteps+1];
   assign chain[0] = abs_ff;

   for (genvar k = 0; k < qrm_pkg::DivSteps; k++) begin : g_div
      qrm_pkg::div_type  dv_ff;
      qrm_pkg::div_type  dv_in;
      qrm_pkg::step_type st [NE];

      always_comb begin
         dv_in = chain[k];
         for (int i = 0; i < NE; i++) begin
            st[i]        = qrm_pkg::div_step(chain[k].rem[i], chain[k].norm, (k != 0));
            dv_in.rem[i] = st[i].rem;
            dv_in.quo[i] = {chain[k].quo[i][qrm_pkg::QuoW-2:0], st[i].qbit};
         end
      end

      always_ff @(posedge clock) begin
         if (en[3+k]) begin
            dv_ff <= dv_in;
         end
      end

      assign chain[k+1] = dv_ff;
   end

   // round half away, saturate, apply sign
   logic signed [31:0] mat_ff [NE];
   logic signed [31:0] mat_in [NE];
   logic               zero_ff;
   logic [qrm_pkg::QuoW:0]   rnd;
   logic [qrm_pkg::QuoW-1:0] mag;

   always_comb begin
      rnd = '0;
      mag = '0;
      for (int i = 0; i < NE; i++) begin
         rnd = {1'b0, chain[qrm_pkg::DivSteps].quo[i]} + 1'b1;
         mag = rnd[qrm_pkg::QuoW:1];
         if (mag > qrm_pkg::OneQ30) begin
            mag = qrm_pkg::OneQ30;
         end
         if (chain[qrm_pkg::DivSteps].zero) begin
            mat_in[i] = '0;
         end else if (chain[qrm_pkg::DivSteps].neg[i]) begin
            mat_in[i] = -$signed(mag);
         end else begin
            mat_in[i] = $signed(mag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS-1]) begin
         mat_ff  <= mat_in;
         zero_ff <= chain[qrm_pkg::DivSteps].zero;
      end
   end

   assign rsp_ch.valid     = vld_ff[NS-1];
   assign rsp_ch.m00       = mat_ff[0];
   assign rsp_ch.m01       = mat_ff[1];
   assign rsp_ch.m02       = mat_ff[2];
   assign rsp_ch.m10       = mat_ff[3];
   assign rsp_ch.m11       = mat_ff[4];
   assign rsp_ch.m12       = mat_ff[5];
   assign rsp_ch.m20       = mat_ff[6];
   assign rsp_ch.m21       = mat_ff[7];
   assign rsp_ch.m22       = mat_ff[8];
   assign rsp_ch.zero_norm = zero_ff;

   a_zero_mat: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.zero_norm |-> rsp_ch.m00 == 0 && rsp_ch.m11 == 0
                                            && rsp_ch.m22 == 0 && rsp_ch.m01 == 0)
      else $error("zero quaternion gave nonzero entry");

   a_reset_empty: assert property (@(posedge clock) reset |=> vld_ff == '0)
      else $error("pipeline not empty after reset");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> &vld_ff)
      else $error("input stalled with a bubble in the pipeline");

   a_diag_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> $signed(rsp_ch.m00) <= $signed(qrm_pkg::OneQ30)
                       && $signed(rsp_ch.m00) >= -$signed(qrm_pkg::OneQ30))
      else $error("entry out of range");

endmodule
`default_nettype wire
